[sv/dth_pkg.sv]
// Shared types and constants for the deadline timer heap.
package dth_pkg;

    localparam int DL_W = 48;
    localparam int ID_W = 32;
    localparam int TO_W = 32;

    typedef struct packed {
        logic [DL_W-1:0] dl;
        logic [ID_W-1:0] id;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ADDED    = 3'd0,
        KIND_DELETED  = 3'd1,
        KIND_NOTFOUND = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_EXPIRED  = 3'd4
    } t_kind;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ADD_INIT,
        OP_SU_RD,
        OP_SU_SWAP,
        OP_WR_CUR,
        OP_SD_RDL,
        OP_SD_RDR,
        OP_SD_CAPL,
        OP_SD_SWAP,
        OP_DS_INIT,
        OP_DS_STEP,
        OP_DEL_FOUND,
        OP_RD_LAST,
        OP_CAP_CUR,
        OP_TICK,
        OP_RD_ROOT,
        OP_TK_CAP,
        OP_TK_NODUE,
        OP_POP,
        OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SU_CHK,
        ST_SU_CMP,
        ST_SD_CHK,
        ST_SD_L,
        ST_SD_CMP,
        ST_DS_SCAN,
        ST_RM_CHK,
        ST_RM_CAP,
        ST_RM_PRD,
        ST_RM_PAR,
        ST_TK_RD,
        ST_TK_CHK,
        ST_TK_DEC,
        ST_TK_EMIT,
        ST_TK_POP,
        ST_EMIT_DONE
    } t_state;

    typedef struct packed {
        t_op   op;
        t_kind kind;
        logic  last;
        logic  in_rdy;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic pos_zero;
        logic left_ge;
        logic right_lt;
        logic sd_swap;
        logic su_swap;
        logic par_gt;
        logic ds_match;
        logic ds_end;
        logic pos_at_count;
        logic count_zero;
        logic due_r;
        logic have;
        logic out_free;
    } t_sts;

endpackage

[sv/dth_cmd_if.sv]
// Command channel: add, delete, tick or no-op.
interface dth_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] delay_ms;
    logic [31:0] target_id;

    modport source (output valid, output cmd, output delay_ms, output target_id,
                    input ready);
    modport sink   (input valid, input cmd, input delay_ms, input target_id,
                    output ready);
endinterface

[sv/dth_evt_if.sv]
// Event channel: one result of a command.
interface dth_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [31:0] result_id;
    logic        last;

    modport source (output valid, output event_kind, output result_id, output last,
                    input ready);
    modport sink   (input valid, input event_kind, input result_id, input last,
                    output ready);
endinterface

[sv/deadline_timer_heap.sv]
// Deadline timer queue top level: min-heap of deadlines with controller and datapath.
//
//  channel  | dir | handshake     | payload
//  i_cmd    | in  | valid / ready | cmd, delay_ms, target_id
//  o_evt    | out | valid / ready | event_kind, result_id, last
//
//  One command at a time; the heap sits in a single RAM with one read and one write
//  port. Add sifts the new timer up from the end of the heap. Delete searches the
//  entries in order, then refills the freed slot with the last entry and sifts it up
//  or down. Tick advances the clock and pops each expired timer from the root,
//  sifting the refill down.
//  Synchronous active-low reset empties the heap, zeroes the clock and the id counter.
//  A stalled event output holds the next event back; a new command is taken meanwhile.
module deadline_timer_heap #(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    dth_cmd_if.sink    i_cmd,
    dth_evt_if.source  o_evt
);
    import dth_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    dth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    dth_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_in_valid   (i_cmd.valid),
        .i_in_cmd     (i_cmd.cmd),
        .i_in_timeout (i_cmd.delay_ms),
        .i_in_target  (i_cmd.target_id),
        .o_sts        (w_sts),
        .o_out_valid  (o_evt.valid),
        .i_out_ready  (o_evt.ready),
        .o_out_kind   (o_evt.event_kind),
        .o_out_id     (o_evt.result_id),
        .o_out_last   (o_evt.last)
    );

    assign i_cmd.ready = w_ctl.in_rdy;
endmodule

[sv/dth_ram.sv]
// Generic RAM: one write port, one read port with registered read data.
module dth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/dth_datapath.sv]
// Heap datapath: entry store, counters, compare logic and the result register.
module dth_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dth_pkg::t_ctl        i_ctl,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_in_cmd,
    input  logic [31:0]          i_in_timeout,
    input  logic [31:0]          i_in_target,
    output dth_pkg::t_sts        o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_out_kind,
    output logic [31:0]          o_out_id,
    output logic                 o_out_last
);
    import dth_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    logic [1:0]      r_cmd;
    logic [TO_W-1:0] r_timeout;
    logic [ID_W-1:0] r_target;
    logic [CW-1:0]   r_count,   n_count;
    logic [ID_W-1:0] r_last_id, n_last_id;
    logic [DL_W-1:0] r_now,     n_now;
    logic [AW-1:0]   r_pos,     n_pos;
    t_entry          r_cur,     n_cur;
    t_entry          r_l,       n_l;
    logic            r_two,     n_two;
    logic [CW-1:0]   r_i,       n_i;
    logic            r_pv,      n_pv;
    logic [ID_W-1:0] r_pend,    n_pend;
    logic [ID_W-1:0] r_top_id,  n_top_id;
    logic            r_due,     n_due;
    logic            r_have,    n_have;
    logic            r_ovalid,  n_ovalid;
    logic [2:0]      r_okind,   n_okind;
    logic [ID_W-1:0] r_oid,     n_oid;
    logic            r_olast,   n_olast;

    logic                    w_we, w_re;
    logic [AW-1:0]           w_waddr, w_raddr;
    t_entry                  w_wdata;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry                  w_rd;
    logic [XW-1:0]           w_left, w_right, w_cnt_x;
    logic [AW-1:0]           w_parent;
    logic                    w_pick_right;
    t_entry                  w_child;
    logic [AW-1:0]           w_child_idx;
    logic                    w_out_free;

    dth_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd         = t_entry'(w_rdata);
    assign w_left       = {1'b0, r_pos, 1'b1};
    assign w_right      = {1'b0, r_pos, 1'b0} + XW'(2);
    assign w_cnt_x      = XW'(r_count);
    assign w_parent     = (r_pos - AW'(1)) >> 1;
    // right child wins ties, left only when strictly earlier
    assign w_pick_right = r_two && !(r_l.dl < w_rd.dl);
    assign w_child      = w_pick_right ? w_rd : r_l;
    assign w_child_idx  = w_pick_right ? w_right[AW-1:0] : w_left[AW-1:0];
    assign w_out_free   = !r_ovalid || i_out_ready;

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_pos;
        w_raddr = '0;
        w_wdata = r_cur;
        case (i_ctl.op)
            OP_SU_RD: begin
                w_re    = 1'b1;
                w_raddr = w_parent;
            end
            OP_SU_SWAP: begin
                w_we    = 1'b1;
                w_wdata = w_rd;
            end
            OP_WR_CUR: begin
                w_we = 1'b1;
            end
            OP_SD_RDL: begin
                w_re    = 1'b1;
                w_raddr = w_left[AW-1:0];
            end
            OP_SD_RDR: begin
                w_re    = 1'b1;
                w_raddr = w_right[AW-1:0];
            end
            OP_SD_SWAP: begin
                w_we    = 1'b1;
                w_wdata = w_child;
            end
            OP_DS_STEP: begin
                w_re    = 1'b1;
                w_raddr = r_i[AW-1:0];
            end
            OP_RD_LAST: begin
                w_re    = 1'b1;
                w_raddr = r_count[AW-1:0];
            end
            OP_RD_ROOT: begin
                w_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_last_id = r_last_id;
        n_now     = r_now;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_l       = r_l;
        n_two     = r_two;
        n_i       = r_i;
        n_pv      = r_pv;
        n_pend    = r_pend;
        n_top_id  = r_top_id;
        n_due     = r_due;
        n_have    = r_have;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_okind   = r_okind;
        n_oid     = r_oid;
        n_olast   = r_olast;
        case (i_ctl.op)
            OP_ADD_INIT: begin
                n_last_id = (r_last_id == '1) ? ID_W'(1) : r_last_id + ID_W'(1);
                n_cur.dl  = r_now + DL_W'(r_timeout);
                n_cur.id  = n_last_id;
                n_pos     = r_count[AW-1:0];
                n_count   = r_count + CW'(1);
            end
            OP_SU_SWAP: n_pos = w_parent;
            OP_SD_RDR: begin
                n_l   = w_rd;
                n_two = 1'b1;
            end
            OP_SD_CAPL: begin
                n_l   = w_rd;
                n_two = 1'b0;
            end
            OP_SD_SWAP: n_pos = w_child_idx;
            OP_DS_INIT: begin
                n_i  = '0;
                n_pv = 1'b0;
            end
            OP_DS_STEP: begin
                n_i  = r_i + CW'(1);
                n_pv = 1'b1;
            end
            OP_DEL_FOUND: begin
                n_pos   = AW'(r_i - CW'(1));
                n_count = r_count - CW'(1);
            end
            OP_CAP_CUR: n_cur = w_rd;
            OP_TICK: begin
                n_now  = r_now + DL_W'(1);
                n_have = 1'b0;
            end
            OP_TK_CAP: begin
                n_due    = (w_rd.dl <= r_now);
                n_top_id = w_rd.id;
            end
            OP_TK_NODUE: n_due = 1'b0;
            OP_POP: begin
                n_pend  = r_top_id;
                n_have  = 1'b1;
                n_pos   = '0;
                n_count = r_count - CW'(1);
            end
            OP_EMIT: begin
                n_ovalid = 1'b1;
                n_okind  = i_ctl.kind;
                n_olast  = i_ctl.last;
                case (i_ctl.kind)
                    KIND_ADDED:    n_oid = r_last_id;
                    KIND_DELETED:  n_oid = r_target;
                    KIND_NOTFOUND: n_oid = r_target;
                    KIND_EXPIRED:  n_oid = r_pend;
                    default:       n_oid = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_last_id <= '0;
            r_now     <= '0;
            r_ovalid  <= 1'b0;
            r_have    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_last_id <= n_last_id;
            r_now     <= n_now;
            r_ovalid  <= n_ovalid;
            r_have    <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.in_rdy && i_in_valid) begin
            r_cmd     <= i_in_cmd;
            r_timeout <= i_in_timeout;
            r_target  <= i_in_target;
        end
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_l      <= n_l;
        r_two    <= n_two;
        r_i      <= n_i;
        r_pv     <= n_pv;
        r_pend   <= n_pend;
        r_top_id <= n_top_id;
        r_due    <= n_due;
        r_okind  <= n_okind;
        r_oid    <= n_oid;
        r_olast  <= n_olast;
    end

    always_comb begin
        o_sts.cmd          = t_cmd'(r_cmd);
        o_sts.full         = (r_count == CW'(CAPACITY));
        o_sts.pos_zero     = (r_pos == '0);
        o_sts.left_ge      = (w_left >= w_cnt_x);
        o_sts.right_lt     = (w_right < w_cnt_x);
        o_sts.sd_swap      = (r_cur.dl > w_child.dl);
        o_sts.su_swap      = (r_cur.dl < w_rd.dl);
        o_sts.par_gt       = (r_cur.dl > w_rd.dl);
        o_sts.ds_match     = r_pv && (w_rd.id == r_target);
        o_sts.ds_end       = (r_i >= r_count);
        o_sts.pos_at_count = (CW'(r_pos) == r_count);
        o_sts.count_zero   = (r_count == '0);
        o_sts.due_r        = r_due;
        o_sts.have         = r_have;
        o_sts.out_free     = w_out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_kind  = r_okind;
    assign o_out_id    = r_oid;
    assign o_out_last  = r_olast;
endmodule

[sv/dth_ctrl.sv]
// Controller state machine: sequences search, sift and pop steps on the datapath.
module dth_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  dth_pkg::t_sts i_sts,
    output dth_pkg::t_ctl o_ctl
);
    import dth_pkg::*;

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;
    t_state w_done;

    // where a finished sift returns to
    assign w_done = (i_sts.cmd == CMD_TICK) ? ST_TK_RD : ST_EMIT_DONE;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                case (i_sts.cmd)
                    CMD_ADD: begin
                        if (i_sts.full) begin
                            n_kind  = KIND_FULL;
                            n_state = ST_EMIT_DONE;
                        end else begin
                            n_kind  = KIND_ADDED;
                            n_state = ST_SU_CHK;
                        end
                    end
                    CMD_DEL:  n_state = ST_DS_SCAN;
                    CMD_TICK: n_state = ST_TK_RD;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_SU_CHK: n_state = i_sts.pos_zero ? w_done : ST_SU_CMP;
            ST_SU_CMP: n_state = i_sts.su_swap ? ST_SU_CHK : w_done;
            ST_SD_CHK: n_state = i_sts.left_ge ? w_done : ST_SD_L;
            ST_SD_L:   n_state = ST_SD_CMP;
            ST_SD_CMP: n_state = i_sts.sd_swap ? ST_SD_CHK : w_done;
            ST_DS_SCAN: begin
                if (i_sts.ds_match) begin
                    n_kind  = KIND_DELETED;
                    n_state = ST_RM_CHK;
                end else if (i_sts.ds_end) begin
                    n_kind  = KIND_NOTFOUND;
                    n_state = ST_EMIT_DONE;
                end
            end
            ST_RM_CHK: n_state = i_sts.pos_at_count ? w_done : ST_RM_CAP;
            ST_RM_CAP: n_state = ST_RM_PRD;
            ST_RM_PRD: n_state = i_sts.pos_zero ? ST_SD_CHK : ST_RM_PAR;
            ST_RM_PAR: n_state = i_sts.par_gt ? ST_SD_CHK : ST_SU_CMP;
            ST_TK_RD:  n_state = i_sts.count_zero ? ST_TK_DEC : ST_TK_CHK;
            ST_TK_CHK: n_state = ST_TK_DEC;
            ST_TK_DEC: begin
                if (i_sts.have) begin
                    n_state = ST_TK_EMIT;
                end else begin
                    n_state = i_sts.due_r ? ST_TK_POP : ST_IDLE;
                end
            end
            ST_TK_EMIT: begin
                if (i_sts.out_free) n_state = i_sts.due_r ? ST_TK_POP : ST_IDLE;
            end
            ST_TK_POP: n_state = ST_RM_CHK;
            ST_EMIT_DONE: if (i_sts.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.op     = OP_NONE;
        o_ctl.kind   = r_kind;
        o_ctl.last   = 1'b1;
        o_ctl.in_rdy = 1'b0;
        case (r_state)
            ST_IDLE: o_ctl.in_rdy = 1'b1;
            ST_DISPATCH: begin
                case (i_sts.cmd)
                    CMD_ADD:  if (!i_sts.full) o_ctl.op = OP_ADD_INIT;
                    CMD_DEL:  o_ctl.op = OP_DS_INIT;
                    CMD_TICK: o_ctl.op = OP_TICK;
                    default:  o_ctl.op = OP_NONE;
                endcase
            end
            ST_SU_CHK: o_ctl.op = i_sts.pos_zero ? OP_WR_CUR : OP_SU_RD;
            ST_SU_CMP: o_ctl.op = i_sts.su_swap ? OP_SU_SWAP : OP_WR_CUR;
            ST_SD_CHK: o_ctl.op = i_sts.left_ge ? OP_WR_CUR : OP_SD_RDL;
            ST_SD_L:   o_ctl.op = i_sts.right_lt ? OP_SD_RDR : OP_SD_CAPL;
            ST_SD_CMP: o_ctl.op = i_sts.sd_swap ? OP_SD_SWAP : OP_WR_CUR;
            ST_DS_SCAN: begin
                if (i_sts.ds_match) begin
                    o_ctl.op = OP_DEL_FOUND;
                end else if (!i_sts.ds_end) begin
                    o_ctl.op = OP_DS_STEP;
                end
            end
            ST_RM_CHK: if (!i_sts.pos_at_count) o_ctl.op = OP_RD_LAST;
            ST_RM_CAP: o_ctl.op = OP_CAP_CUR;
            ST_RM_PRD: if (!i_sts.pos_zero) o_ctl.op = OP_SU_RD;
            ST_TK_RD:  o_ctl.op = i_sts.count_zero ? OP_TK_NODUE : OP_RD_ROOT;
            ST_TK_CHK: o_ctl.op = OP_TK_CAP;
            ST_TK_EMIT: begin
                o_ctl.kind = KIND_EXPIRED;
                o_ctl.last = !i_sts.due_r;
                if (i_sts.out_free) o_ctl.op = OP_EMIT;
            end
            ST_TK_POP: o_ctl.op = OP_POP;
            ST_EMIT_DONE: if (i_sts.out_free) o_ctl.op = OP_EMIT;
            default: o_ctl.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_ADDED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end
endmodule

[sv/dth_checker.sv]
// Port-level checks for the deadline timer heap, bound to the top level.
module dth_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_kind,
    input logic [31:0] i_out_id,
    input logic        i_out_last
);
    import dth_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_id) && $stable(i_out_last))
        else $error("event changed while stalled");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command taken while one is in progress");

    a_full_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_FULL |-> i_out_id == '0 && i_out_last)
        else $error("full event with nonzero id or not last");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_EXPIRED |-> i_out_last)
        else $error("non-expiry event not marked last");
endmodule

bind deadline_timer_heap dth_checker u_dth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_out_kind  (o_evt.event_kind),
    .i_out_id    (o_evt.result_id),
    .i_out_last  (o_evt.last)
);

[sim/tb_deadline_timer_heap.sv]
// Self-checking testbench for the deadline timer heap: predictor, command driver, event checker.
module tb_deadline_timer_heap;
    import dth_pkg::*;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        t_kind       kind;
        logic [31:0] id;
        logic        last;
    } t_evt_exp;

    logic i_clk;
    logic i_rst_n;

    dth_cmd_if cmd_bus ();
    dth_evt_if evt_bus ();

    deadline_timer_heap #(.CAPACITY(CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_evt   (evt_bus.source)
    );

    // predicted timer state
    logic [47:0] heap_dl [CAP];
    logic [31:0] heap_tid [CAP];
    int          heap_cnt;
    logic [31:0] issued_id;
    logic [47:0] clock_ms;

    t_evt_exp pending_events [$];
    int       error_count;
    int       cycle_count;
    bit       quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 28);
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [47:0] d;
        logic [31:0] k;
        d = heap_dl[a];
        k = heap_tid[a];
        heap_dl[a] = heap_dl[b];
        heap_tid[a] = heap_tid[b];
        heap_dl[b] = d;
        heap_tid[b] = k;
    endfunction

    function automatic void sift_up(int p);
        int parent;
        while (p > 0) begin
            parent = (p - 1) / 2;
            if (heap_dl[p] < heap_dl[parent]) swap_slots(p, parent);
            p = parent;
        end
    endfunction

    function automatic void sift_down(int p);
        int right;
        int child;
        forever begin
            right = 2 * p + 2;
            if (right < heap_cnt) begin
                child = right;
                if (heap_dl[right-1] < heap_dl[right]) child = right - 1;
                if (heap_dl[p] > heap_dl[child]) swap_slots(p, child);
                p = child;
            end else begin
                if (right - 1 < heap_cnt && heap_dl[p] > heap_dl[right-1])
                    swap_slots(p, right - 1);
                return;
            end
        end
    endfunction

    function automatic void remove_timer(int p);
        int lastpos;
        lastpos = heap_cnt - 1;
        if (p != lastpos) swap_slots(p, lastpos);
        heap_cnt = lastpos;
        if (p < heap_cnt) begin
            if (p == 0) sift_down(p);
            else if (heap_dl[p] > heap_dl[(p-1)/2]) sift_down(p);
            else sift_up(p);
        end
    endfunction

    function automatic void expect_evt(t_kind k, logic [31:0] id, logic lst);
        t_evt_exp e;
        e.kind = k;
        e.id = id;
        e.last = lst;
        pending_events.push_back(e);
    endfunction

    function automatic void predict_timer_events(t_cmd c, logic [31:0] to, logic [31:0] tid);
        int n;
        bit hit;
        case (c)
            CMD_ADD: begin
                if (heap_cnt >= CAP) begin
                    expect_evt(KIND_FULL, 32'd0, 1'b1);
                end else begin
                    issued_id = (issued_id == 32'hFFFF_FFFF) ? 32'd1 : issued_id + 1;
                    heap_dl[heap_cnt] = clock_ms + {16'd0, to};
                    heap_tid[heap_cnt] = issued_id;
                    heap_cnt++;
                    sift_up(heap_cnt - 1);
                    expect_evt(KIND_ADDED, issued_id, 1'b1);
                end
            end
            CMD_DEL: begin
                hit = 0;
                for (int i = 0; i < heap_cnt; i++) begin
                    if (!hit && heap_tid[i] == tid) begin
                        hit = 1;
                        remove_timer(i);
                    end
                end
                expect_evt(hit ? KIND_DELETED : KIND_NOTFOUND, tid, 1'b1);
            end
            CMD_TICK: begin
                n = 0;
                clock_ms = clock_ms + 1;
                while (heap_cnt > 0 && heap_dl[0] <= clock_ms && n < CAP) begin
                    expect_evt(KIND_EXPIRED, heap_tid[0], 1'b0);
                    remove_timer(0);
                    n++;
                end
                if (n > 0) pending_events[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_cmd(t_cmd c, logic [31:0] to, logic [31:0] tid);
        while (idle_roll()) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.cmd        <= c;
        cmd_bus.delay_ms   <= to;
        cmd_bus.target_id  <= tid;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        predict_timer_events(c, to, tid);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        evt_bus.ready <= !idle_roll();
    end

    always @(posedge i_clk) begin
        t_evt_exp e;
        if (i_rst_n && evt_bus.valid && evt_bus.ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event kind=%0d id=%0h last=%0b", $time,
                         evt_bus.event_kind, evt_bus.result_id, evt_bus.last);
                error_count++;
            end else begin
                e = pending_events.pop_front();
                if (evt_bus.event_kind !== e.kind) begin
                    $display("%0t: event_kind expected %0d actual %0d", $time,
                             e.kind, evt_bus.event_kind);
                    error_count++;
                end
                if (evt_bus.result_id !== e.id) begin
                    $display("%0t: result_id expected %0h actual %0h", $time,
                             e.id, evt_bus.result_id);
                    error_count++;
                end
                if (evt_bus.last !== e.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             e.last, evt_bus.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_extremes();
        send_cmd(CMD_TICK, 32'd0, 32'd0);               // nothing due
        send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD, 32'd0, 32'd0);
        send_cmd(CMD_DEL, 32'd0, 32'd0);                // miss
        send_cmd(CMD_DEL, 32'd0, 32'hFFFF_FFFF);        // miss
        send_cmd(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // ignored
        send_cmd(CMD_TICK, 32'd0, 32'd0);               // pops the zero-timeout timer
        send_cmd(CMD_DEL, 32'hFFFF_FFFF, 32'd1);        // removes the long one
        send_cmd(CMD_DEL, 32'd0, 32'd1);                // already gone
    endtask

    // fill to capacity, overflow, delete from the middle and the end, refill, then expire everything over four ticks
    task automatic test_full_and_burst();
        while (heap_cnt < CAP) send_cmd(CMD_ADD, $urandom_range(4, 1), 32'd0);
        send_cmd(CMD_ADD, 32'd7, 32'd0);
        send_cmd(CMD_DEL, 32'd0, heap_tid[heap_cnt/2]);
        send_cmd(CMD_DEL, 32'd0, heap_tid[heap_cnt-1]);
        send_cmd(CMD_ADD, 32'd0, 32'd0);
        send_cmd(CMD_ADD, 32'd1, 32'd0);
        send_cmd(CMD_ADD, 32'd2, 32'd0);
        while (heap_cnt < CAP) send_cmd(CMD_ADD, 32'd4, 32'd0);
        repeat (4) send_cmd(CMD_TICK, 32'd0, 32'd0);
    endtask

    task automatic test_random(int n_items);
        int r;
        int sent;
        logic [31:0] to;
        logic [31:0] tid;
        sent = 0;
        while (sent < n_items) begin
            quiet = (sent >= 100 && sent < 160);
            r = $urandom_range(99);
            to = $urandom;
            tid = $urandom;
            if (r < 40) begin
                r = $urandom_range(9);
                if (r < 7) to = $urandom_range(30);
                else if (r < 9) to = $urandom_range(300);
                send_cmd(CMD_ADD, to, tid);
                sent++;
            end else if (r < 65) begin
                r = $urandom_range(9);
                if (r < 7 && heap_cnt > 0) tid = heap_tid[$urandom_range(heap_cnt - 1)];
                else if (r < 9) tid = issued_id + 1;
                send_cmd(CMD_DEL, to, tid);
                sent++;
            end else if (r < 95) begin
                send_cmd(CMD_TICK, to, tid);
                sent++;
            end else begin
                send_cmd(CMD_NOP, to, tid);
            end
        end
        quiet = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.cmd = CMD_ADD;
        cmd_bus.delay_ms = '0;
        cmd_bus.target_id = '0;
        evt_bus.ready = 1'b0;
        heap_cnt = 0;
        issued_id = '0;
        clock_ms = '0;
        error_count = 0;
        cycle_count = 0;
        quiet = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_full_and_burst();
        test_random(190);

        cmd_bus.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
